[rtl/nsr_pkg.sv]
// ----------------------------------------------------------------------------
// nsr_pkg
// Shared widths, register map, reset values and types for the Newton square
// root unit.
// ----------------------------------------------------------------------------
package nsr_pkg;

  // Defaults for the top-level parameters
  localparam int FRAC_BITS_DEF  = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed field widths
  localparam int RADICAND_W = 32;
  localparam int ROOT_W     = 24;
  localparam int STEPS_W    = 6;
  localparam int TOL_W      = 16;
  localparam int LIMIT_W    = 6;

  localparam logic [ROOT_W-1:0] ROOT_MAX = '1;

  // APB register map: one 32-bit register every 4 bytes
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_TOLERANCE  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_ITER_LIMIT = 1'b1;

  localparam logic [TOL_W-1:0]   TOLERANCE_RST  = 16'd7;
  localparam logic [LIMIT_W-1:0] ITER_LIMIT_RST = 6'd32;

  typedef struct packed {
    logic [TOL_W-1:0]   tolerance;
    logic [LIMIT_W-1:0] iteration_limit;
  } cfg_t;

endpackage

[rtl/nsr_cfg_regs.sv]
// ----------------------------------------------------------------------------
// nsr_cfg_regs
// APB register file holding the tolerance and the iteration limit.
// ----------------------------------------------------------------------------
module nsr_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [nsr_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [nsr_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [nsr_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  output nsr_pkg::cfg_t                    cfg
);

  logic [nsr_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          wr_en;

  assign reg_idx = paddr[nsr_pkg::APB_ADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tolerance       <= nsr_pkg::TOLERANCE_RST;
      cfg.iteration_limit <= nsr_pkg::ITER_LIMIT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        nsr_pkg::REG_TOLERANCE: begin
          cfg.tolerance <= pwdata[nsr_pkg::TOL_W-1:0];
        end
        nsr_pkg::REG_ITER_LIMIT: begin
          cfg.iteration_limit <= pwdata[nsr_pkg::LIMIT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      nsr_pkg::REG_TOLERANCE:  prdata = nsr_pkg::APB_DATA_W'(cfg.tolerance);
      nsr_pkg::REG_ITER_LIMIT: prdata = nsr_pkg::APB_DATA_W'(cfg.iteration_limit);
      default:                 prdata = '0;
    endcase
  end

endmodule

[rtl/nsr_serial_div.sv]
// ----------------------------------------------------------------------------
// nsr_serial_div
// Bit-serial restoring divider: floor((dividend << FRAC_BITS) / divisor),
// one quotient bit per cycle, saturating to all ones on overflow.
// ----------------------------------------------------------------------------
module nsr_serial_div #(
  parameter  int DATA_WIDTH = nsr_pkg::DATA_WIDTH_DEF,
  parameter  int FRAC_BITS  = nsr_pkg::FRAC_BITS_DEF,
  localparam int TOTAL      = DATA_WIDTH + FRAC_BITS,
  localparam int QW         = (TOTAL > 64) ? 64 : TOTAL
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DATA_WIDTH-1:0] dividend,
  input  logic [QW-1:0]         divisor,
  output logic                  done,
  output logic [QW-1:0]         quotient
);

  localparam int CW = $clog2(TOTAL + 1);
  localparam int SW = QW + 2;

  logic                  active;
  logic [CW-1:0]         cnt;
  logic [DATA_WIDTH-1:0] num;
  logic [QW-1:0]         rem;
  logic [QW-1:0]         quo;
  logic                  sat;

  logic [QW:0]   rem_sh;
  logic [SW-1:0] trial;
  logic          ge;
  logic [QW-1:0] rem_next;

  // Numerator bits come out MSB first; zeros follow for the fraction shift.
  assign rem_sh   = {rem, num[DATA_WIDTH-1]};
  assign trial    = SW'(rem_sh) - SW'(divisor);
  assign ge       = ~trial[SW-1];
  assign rem_next = ge ? trial[QW-1:0] : rem_sh[QW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= CW'(TOTAL);
      end else if (active) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      rem <= '0;
      quo <= '0;
      sat <= 1'b0;
    end else if (active) begin
      num <= {num[DATA_WIDTH-2:0], 1'b0};
      rem <= rem_next;
      quo <= {quo[QW-2:0], ge};
      sat <= sat | quo[QW-1];
    end
  end

  assign quotient = sat ? '1 : quo;

endmodule

[rtl/newton_square_root_unit.sv]
// ----------------------------------------------------------------------------
// newton_square_root_unit
// Square root of an unsigned fixed-point radicand by Newton (Heron) steps.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken when start is high and busy is low; radicand is
//   sampled at that edge. Exactly one result per request comes back on
//   root, steps_used and limit_hit, valid for the single cycle in which done
//   is high. The receiver cannot stall, so results must be taken then.
//   busy stays high from a nonzero request until the cycle done is high.
// Sequence:
//   A zero radicand returns straight from idle. Otherwise every Newton step
//   launches the bit-serial divider, which produces one quotient bit per
//   cycle, picks up its quotient, forms the difference of guess and
//   quotient, then runs the check/update that either ends the request or
//   starts the next step.
// Configuration: tolerance at byte address 0, iteration_limit at 4. The
//   user must write them over APB only while idle; the unit does not
//   enforce it. Reset restores 7 and 32 and returns the unit to idle.
// ----------------------------------------------------------------------------
module newton_square_root_unit #(
  parameter int FRAC_BITS  = nsr_pkg::FRAC_BITS_DEF,
  parameter int DATA_WIDTH = nsr_pkg::DATA_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [nsr_pkg::RADICAND_W-1:0]  radicand,
  output logic                            done,
  output logic [nsr_pkg::ROOT_W-1:0]      root,
  output logic [nsr_pkg::STEPS_W-1:0]     steps_used,
  output logic                            limit_hit,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [nsr_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [nsr_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [nsr_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);

  localparam int TOTAL = DATA_WIDTH + FRAC_BITS;
  localparam int QW    = (TOTAL > 64) ? 64 : TOTAL;
  localparam int SW    = QW + 1;
  localparam int CMPW  = (QW > nsr_pkg::TOL_W) ? QW : nsr_pkg::TOL_W;
  localparam int GW    = (QW > nsr_pkg::ROOT_W) ? QW : nsr_pkg::ROOT_W;
  localparam int RXW   = (DATA_WIDTH > nsr_pkg::RADICAND_W) ? DATA_WIDTH
                                                            : nsr_pkg::RADICAND_W;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_DIV   = 4'b0010,
    ST_DIFF  = 4'b0100,
    ST_CHECK = 4'b1000
  } state_t;

  state_t                        state;
  nsr_pkg::cfg_t                 cfg;
  logic [DATA_WIDTH-1:0]         rad;
  logic [QW-1:0]                 guess;
  logic [QW-1:0]                 mag;
  logic [nsr_pkg::STEPS_W-1:0]   steps;
  logic                          div_go;
  logic                          div_done;
  logic [QW-1:0]                 quo;

  logic [RXW-1:0]                rad_ext;
  logic [DATA_WIDTH-1:0]         rad_in;
  logic [QW-1:0]                 half;
  logic [QW-1:0]                 guess_init;
  logic [SW-1:0]                 g_minus_q;
  logic [QW-1:0]                 q_minus_g;
  logic [QW-1:0]                 mag_next;
  logic                          converged;
  logic                          limit_reached;
  logic [SW-1:0]                 mean_sum;
  logic [QW-1:0]                 guess_next;
  logic [GW-1:0]                 guess_ext;
  logic [nsr_pkg::ROOT_W-1:0]    root_next;

  nsr_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  nsr_serial_div #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (rad),
    .divisor  (guess),
    .done     (div_done),
    .quotient (quo)
  );

  assign rad_ext    = RXW'(radicand);
  assign rad_in     = rad_ext[DATA_WIDTH-1:0];
  assign half       = QW'(rad_in >> 1);
  // a guess of zero would divide by zero; bump it to one lsb
  assign guess_init = (half == '0) ? QW'(1) : half;

  assign g_minus_q  = SW'(guess) - SW'(quo);
  assign q_minus_g  = quo - guess;
  assign mag_next   = g_minus_q[SW-1] ? q_minus_g : g_minus_q[QW-1:0];

  assign converged     = CMPW'(mag) <= CMPW'(cfg.tolerance);
  assign limit_reached = steps >= cfg.iteration_limit;

  // mean of guess and quotient without overflow
  assign mean_sum   = SW'(guess >> 1) + SW'(quo >> 1) + SW'(guess[0] & quo[0]);
  assign guess_next = (mean_sum[QW-1:0] == '0) ? QW'(1) : mean_sum[QW-1:0];

  assign guess_ext  = GW'(guess);
  assign root_next  = (guess_ext > GW'(nsr_pkg::ROOT_MAX)) ? nsr_pkg::ROOT_MAX
                                                           : guess_ext[nsr_pkg::ROOT_W-1:0];

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      done   <= 1'b0;
      div_go <= 1'b0;
    end else begin
      done   <= 1'b0;
      div_go <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            if (rad_in == '0) begin
              root       <= '0;
              steps_used <= '0;
              limit_hit  <= 1'b0;
              done       <= 1'b1;
            end else begin
              rad    <= rad_in;
              guess  <= guess_init;
              steps  <= '0;
              div_go <= 1'b1;
              state  <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_DIFF;
          end
        end
        ST_DIFF: begin
          mag   <= mag_next;
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          if (converged || limit_reached) begin
            root       <= root_next;
            steps_used <= steps;
            limit_hit  <= ~converged;
            done       <= 1'b1;
            state      <= ST_IDLE;
          end else begin
            guess  <= guess_next;
            steps  <= steps + 1'b1;
            div_go <= 1'b1;
            state  <= ST_DIV;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/nsr_checker.sv]
// ----------------------------------------------------------------------------
// nsr_checker
// Port-level checks for the Newton square root unit, bound to the top level.
// ----------------------------------------------------------------------------
module nsr_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // a request either starts work or answers at once
  a_req_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("request neither started work nor returned a result");

  // work only ends by delivering its result
  a_end_has_result: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy dropped without a result strobe");

  a_result_when_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while still busy");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!busy && !done))
    else $error("unit not idle after reset");

endmodule

bind newton_square_root_unit nsr_checker u_nsr_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);
